// ===== rtl/core/ftlru_pkg.sv =====
// Package: sizes and item types for the flow table LRU update unit.
`timescale 1ns / 1ps
`default_nettype none
package ftlru_pkg;

   localparam int FLOW_ENTRIES  = 1024;
   localparam int IDX_W         = $clog2(FLOW_ENTRIES);
   localparam int OCC_W         = $clog2(FLOW_ENTRIES + 1);
   localparam int ENTRY_INDEX_W = 10;
   localparam int KEY_W         = 104;
   localparam int CNT_W         = 128;

   localparam logic [1:0] STATUS_HIT   = 2'd0;
   localparam logic [1:0] STATUS_NEW   = 2'd1;
   localparam logic [1:0] STATUS_EVICT = 2'd2;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port_num;
      logic [15:0] dst_port_num;
      logic [7:0]  proto_num;
      logic [15:0] packet_length;
      logic [63:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [ENTRY_INDEX_W-1:0]   entry_index;
      logic [31:0]                packet_total;
      logic [31:0]                byte_total;
      logic [63:0]                flow_start_time;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/flow_table_lru_update_unit.sv =====
// Top level: flow table with exact-match lookup and LRU eviction.
//
// Usage:
//  - Input channel: an item (flow key, length, timestamp) on req_item is
//    taken at a rising edge with start high and busy low.
//  - Result channel: one result per item on rsp_item, valid for exactly one
//    cycle while rsp_strobe is high. The receiver cannot stall.
//  - Lookup is a linear scan over occupied slots 0 .. occupancy-1 held in a
//    registered-read key memory; each slot is read, then compared.
//  - Hit: the slot's counters and links are read, then the counters are
//    updated and the result registered. When the slot is not the newest,
//    busy stays high through the strobe while the relinking is written.
//  - Miss: a full table first reads the oldest slot's link; the new slot is
//    then written and the result registered. An empty table skips the scan.
//  - Throughput is one item per scan, so the time per item grows with the
//    number of live flows; the key memory read port paces the scan.
//  - Recency list: newer/older link memories, with newest/oldest pointers
//    and occupancy in flip-flops. Hits move the slot to the newest end.
//  - Reset clears occupancy and the list ends; the slot memories are not
//    cleared, as no slot at or above occupancy is ever read.
//  - busy stays high from acceptance until the last memory write is done.
`timescale 1ns / 1ps
`default_nettype none
module flow_table_lru_update_unit
   import ftlru_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SC_RD  = 3'd1;
   localparam logic [2:0] ST_SC_CMP = 3'd2;
   localparam logic [2:0] ST_HT_RD  = 3'd3;
   localparam logic [2:0] ST_HT_UPD = 3'd4;
   localparam logic [2:0] ST_HT_W2  = 3'd5;
   localparam logic [2:0] ST_MS_RD  = 3'd6;
   localparam logic [2:0] ST_MS_WR  = 3'd7;

   // slot memories
   logic [KEY_W-1:0] key_mem   [FLOW_ENTRIES];
   logic [CNT_W-1:0] cnt_mem   [FLOW_ENTRIES];  // {pkt, bytes, first time}
   logic [IDX_W-1:0] newer_mem [FLOW_ENTRIES];
   logic [IDX_W-1:0] older_mem [FLOW_ENTRIES];

   logic [2:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] newest_ff, newest_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic [KEY_W-1:0] key_rd_ff;
   logic [CNT_W-1:0] cnt_rd_ff;
   logic [IDX_W-1:0] newer_rd_ff, older_rd_ff;

   logic [IDX_W-1:0] key_raddr, cnt_raddr, newer_raddr, older_raddr;
   logic             key_we, cnt_we, newer_we, older_we;
   logic [IDX_W-1:0] key_waddr, cnt_waddr, newer_waddr, older_waddr;
   logic [KEY_W-1:0] key_wdata;
   logic [CNT_W-1:0] cnt_wdata;
   logic [IDX_W-1:0] newer_wdata, older_wdata;

   logic [KEY_W-1:0] req_key;
   logic             full;
   logic             scan_last;
   logic [31:0]      hit_pkt, hit_bytes;

   assign req_key   = {req_ff.src_addr, req_ff.dst_addr, req_ff.src_port_num,
                       req_ff.dst_port_num, req_ff.proto_num};
   assign full      = (occ_ff == OCC_W'(FLOW_ENTRIES));
   assign scan_last = ({1'b0, scan_ff} + OCC_W'(1)) == occ_ff;
   assign hit_pkt   = cnt_rd_ff[127:96] + 32'd1;
   assign hit_bytes = cnt_rd_ff[95:64] + {16'd0, req_ff.packet_length};

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      scan_in       = scan_ff;
      slot_in       = slot_ff;
      newest_in     = newest_ff;
      oldest_in     = oldest_ff;
      occ_in        = occ_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      key_raddr   = scan_ff;
      cnt_raddr   = slot_ff;
      newer_raddr = slot_ff;
      older_raddr = slot_ff;
      key_we      = 1'b0;
      cnt_we      = 1'b0;
      newer_we    = 1'b0;
      older_we    = 1'b0;
      key_waddr   = slot_ff;
      cnt_waddr   = slot_ff;
      newer_waddr = newest_ff;
      older_waddr = slot_ff;
      key_wdata   = req_key;
      cnt_wdata   = {32'd1, 16'd0, req_ff.packet_length, req_ff.now_time};
      newer_wdata = slot_ff;
      older_wdata = newest_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in  = req_item;
               scan_in = '0;
               slot_in = '0;
               if (occ_ff == '0) begin
                  state_in = ST_MS_WR;
               end else begin
                  state_in = ST_SC_RD;
               end
            end
         end
         ST_SC_RD: begin
            state_in = ST_SC_CMP;
         end
         ST_SC_CMP: begin
            if (key_rd_ff == req_key) begin
               slot_in  = scan_ff;
               state_in = ST_HT_RD;
            end else if (!scan_last) begin
               scan_in  = scan_ff + IDX_W'(1);
               state_in = ST_SC_RD;
            end else if (full) begin
               slot_in  = oldest_ff;
               state_in = ST_MS_RD;
            end else begin
               slot_in  = occ_ff[IDX_W-1:0];
               state_in = ST_MS_WR;
            end
         end
         ST_HT_RD: begin
            state_in = ST_HT_UPD;
         end
         ST_HT_UPD: begin
            cnt_we    = 1'b1;
            cnt_wdata = {hit_pkt, hit_bytes, cnt_rd_ff[63:0]};
            rsp_strobe_in = 1'b1;
            rsp_in.status          = STATUS_HIT;
            rsp_in.entry_index     = ENTRY_INDEX_W'(slot_ff);
            rsp_in.packet_total    = hit_pkt;
            rsp_in.byte_total      = hit_bytes;
            rsp_in.flow_start_time = cnt_rd_ff[63:0];
            if (slot_ff != newest_ff) begin
               // unlink: older[n] = o, and newer[o] = n or move oldest end
               older_we    = 1'b1;
               older_waddr = newer_rd_ff;
               older_wdata = older_rd_ff;
               if (slot_ff == oldest_ff) begin
                  oldest_in = newer_rd_ff;
               end else begin
                  newer_we    = 1'b1;
                  newer_waddr = older_rd_ff;
                  newer_wdata = newer_rd_ff;
               end
               state_in = ST_HT_W2;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HT_W2: begin
            older_we  = 1'b1;
            newer_we  = 1'b1;
            newest_in = slot_ff;
            state_in  = ST_IDLE;
         end
         ST_MS_RD: begin
            newer_raddr = oldest_ff;
            state_in    = ST_MS_WR;
         end
         ST_MS_WR: begin
            key_we = 1'b1;
            cnt_we = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_in.entry_index     = ENTRY_INDEX_W'(slot_ff);
            rsp_in.packet_total    = 32'd1;
            rsp_in.byte_total      = {16'd0, req_ff.packet_length};
            rsp_in.flow_start_time = req_ff.now_time;
            if (full) begin
               rsp_in.status = STATUS_EVICT;
               oldest_in     = newer_rd_ff;
            end else begin
               rsp_in.status = STATUS_NEW;
               occ_in        = occ_ff + OCC_W'(1);
            end
            if (occ_ff == '0) begin
               newest_in = slot_ff;
               oldest_in = slot_ff;
            end else begin
               older_we  = 1'b1;
               newer_we  = 1'b1;
               newest_in = slot_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         newest_ff     <= '0;
         oldest_ff     <= '0;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         newest_ff     <= newest_in;
         oldest_ff     <= oldest_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      scan_ff <= scan_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_rd_ff <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (newer_we) begin
         newer_mem[newer_waddr] <= newer_wdata;
      end
      newer_rd_ff <= newer_mem[newer_raddr];
   end

   always_ff @(posedge clock) begin
      if (older_we) begin
         older_mem[older_waddr] <= older_wdata;
      end
      older_rd_ff <= older_mem[older_raddr];
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ftlru_checker.sv =====
// Port checker for the flow table LRU update unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module ftlru_checker
   import ftlru_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_item
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without an item in progress");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in a row");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.status == STATUS_HIT || rsp_item.status == STATUS_NEW
                      || rsp_item.status == STATUS_EVICT))
      else $error("bad status code");

endmodule

bind flow_table_lru_update_unit ftlru_checker u_ftlru_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
`default_nettype wire
